// ===== src/gts_pkg.sv =====
package gts_pkg;

	// Field and register widths.
	localparam int CNT_W   = 64;
	localparam int FREQ_W  = 32;
	localparam int SHIFT_W = 3;
	localparam int HI_W    = 32;

	// Conversion constants.
	localparam logic [FREQ_W-1:0] CORE_CLOCK_HZ = 32'd1243125000;
	localparam logic [FREQ_W-1:0] EXACT_FREQ    = 32'd24000000;
	localparam logic [FREQ_W-1:0] EXACT_MUL     = 32'd3315;
	localparam int                PRE_SHIFT     = 3;

	// Two counter bits are consumed per multiply step, two dividend bits per divide step.
	localparam int MUL_STEPS = CNT_W / 2;
	localparam int DIV_STEPS = (CNT_W + HI_W) / 2;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration register indexes.
	localparam logic REG_COUNTER_FREQUENCY = 1'b0;
	localparam logic REG_SPEED_SHIFT       = 1'b1;

	// Request modes.
	localparam logic MODE_READ    = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

endpackage

// ===== src/guest_timebase_scaler.sv =====
// Guest timebase scaler: turns a host counter reading into guest timebase ticks.
// Input channel (in_valid/in_stall) carries mode and counter_now. Mode read returns
// origin ticks plus the scaled counter delta since the origin; mode restart moves the
// origin to counter_now and returns zero. Output channel (out_valid/out_stall) carries
// guest_ticks, exactly one result per request, in order.
// Registers counter_frequency and speed_shift are written through cfg_write/cfg_index/cfg_data,
// which the user must drive only while the block is idle; the block itself does not enforce this.
// A frequency of 24 MHz (or zero) selects the exact path. A restart goes straight to the
// finish state; a read runs the delta multiply and, off the exact path, the divide before
// the elapsed ticks are registered. The delta multiply is serial, two counter bits per
// cycle, and the general path adds a radix-4 restoring divide over the 96-bit product,
// after one load state. One request is in flight at a time; in_stall is high from
// acceptance until the result is loaded, so a new request can follow in the next cycle.
// The output register holds a result while out_stall is high, and a finished request
// waits until it is free.
// Reset (arst_n, asynchronous) clears the origin to zero, sets counter_frequency to
// 24000000 and speed_shift to 0, and empties the output register.
module guest_timebase_scaler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic                           cfg_index,
	input  logic [gts_pkg::FREQ_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [gts_pkg::CNT_W-1:0]      counter_now,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gts_pkg::CNT_W-1:0]      guest_ticks
);
	import gts_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DLOAD = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_ELAP  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]          state_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [SHIFT_W-1:0]  spd_q;
	logic [CNT_W-1:0]    origin_counter_q;
	logic [CNT_W-1:0]    origin_ticks_q;
	logic [SHIFT_W-1:0]  origin_shift_q;
	logic                mode_q;
	logic                fast_q;
	logic [CNT_W-1:0]    now_q;
	logic [CNT_W-1:0]    elapsed_q;
	logic                out_valid_q;
	logic [CNT_W-1:0]    guest_ticks_q;

	logic                accept;
	logic                mul_start;
	logic                mul_done;
	logic                mul_neg;
	logic [HI_W-1:0]     p_hi;
	logic [CNT_W-1:0]    p_lo;
	logic                div_start;
	logic                div_done;
	logic [CNT_W-1:0]    quotient;
	logic                out_load;
	logic [CNT_W-1:0]    fast_elapsed;
	logic [CNT_W-1:0]    slow_elapsed;
	logic [CNT_W-1:0]    ticks;

	// Handshake decode.
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign mul_start = accept && (mode == MODE_READ);
	assign div_start = (state_q == ST_DLOAD);
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	gts_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.fast   ((freq_q == '0) || (freq_q == EXACT_FREQ)),
		.now    (counter_now),
		.org    (origin_counter_q),
		.done   (mul_done),
		.neg    (mul_neg),
		.p_hi   (p_hi),
		.p_lo   (p_lo)
	);

	gts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({p_hi, p_lo}),
		.divisor  (freq_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Elapsed ticks for both paths, and the sum that becomes the result.
	always_comb begin
		fast_elapsed = (p_lo >> PRE_SHIFT) >> origin_shift_q;
		slow_elapsed = (quotient << PRE_SHIFT) >> origin_shift_q;
		ticks        = (mode_q == MODE_RESTART) ? '0 : (origin_ticks_q + elapsed_q);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (mode == MODE_RESTART) ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= fast_q ? ST_ELAP : ST_DLOAD;
					end
				end
				ST_DLOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_ELAP;
					end
				end
				ST_ELAP: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture and elapsed ticks.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			now_q  <= counter_now;
			fast_q <= (freq_q == '0) || (freq_q == EXACT_FREQ);
		end
		if (state_q == ST_ELAP) begin
			elapsed_q <= mul_neg ? '0 : (fast_q ? fast_elapsed : slow_elapsed);
		end
	end

	// Configuration registers and origin state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q           <= EXACT_FREQ;
			spd_q            <= '0;
			origin_counter_q <= '0;
			origin_ticks_q   <= '0;
			origin_shift_q   <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_COUNTER_FREQUENCY: freq_q <= cfg_data;
					REG_SPEED_SHIFT:       spd_q  <= cfg_data[SHIFT_W-1:0];
					default:               freq_q <= freq_q;
				endcase
			end
			// A restart, or a read under a new speed shift, moves the origin.
			if (out_load && ((mode_q == MODE_RESTART) || (spd_q != origin_shift_q))) begin
				origin_counter_q <= now_q;
				origin_ticks_q   <= ticks;
				origin_shift_q   <= spd_q;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			guest_ticks_q <= ticks;
		end
	end

	assign out_valid   = out_valid_q;
	assign guest_ticks = guest_ticks_q;

endmodule

// ===== src/gts_mul.sv =====
module gts_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       fast,
	input  logic [gts_pkg::CNT_W-1:0]  now,
	input  logic [gts_pkg::CNT_W-1:0]  org,
	output logic                       done,
	output logic                       neg,
	output logic [gts_pkg::HI_W-1:0]   p_hi,
	output logic [gts_pkg::CNT_W-1:0]  p_lo
);
	import gts_pkg::*;

	localparam logic [33:0] M1_CORE  = 34'(CORE_CLOCK_HZ);
	localparam logic [33:0] M3_CORE  = 34'(CORE_CLOCK_HZ) * 34'd3;
	localparam logic [33:0] M1_EXACT = 34'(EXACT_MUL);
	localparam logic [33:0] M3_EXACT = 34'(EXACT_MUL) * 34'd3;

	logic                  busy_q;
	logic [MUL_CNT_W-1:0]  cnt_q;
	logic                  fast_q;
	logic                  borrow_q;
	logic [CNT_W-1:0]      now_sr_q;
	logic [CNT_W-1:0]      org_sr_q;
	logic [HI_W-1:0]       acc_q;
	logic [CNT_W-1:0]      p_lo_q;

	logic [2:0]            diff;
	logic [1:0]            digit;
	logic [33:0]           m1;
	logic [33:0]           m3;
	logic [33:0]           part;
	logic [33:0]           sum;

	// One base-4 digit of the delta per cycle: serial subtract, then add digit times constant.
	always_comb begin
		diff  = {1'b0, now_sr_q[1:0]} - {1'b0, org_sr_q[1:0]} - {2'b00, borrow_q};
		digit = diff[1:0];
		m1    = fast_q ? M1_EXACT : M1_CORE;
		m3    = fast_q ? M3_EXACT : M3_CORE;
		case (digit)
			2'd0:    part = '0;
			2'd1:    part = m1;
			2'd2:    part = m1 << 1;
			2'd3:    part = m3;
			default: part = '0;
		endcase
		sum = {2'b00, acc_q} + part;
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operand and product shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			fast_q   <= fast;
			now_sr_q <= now;
			org_sr_q <= org;
			borrow_q <= 1'b0;
			acc_q    <= '0;
		end else if (busy_q) begin
			now_sr_q <= now_sr_q >> 2;
			org_sr_q <= org_sr_q >> 2;
			borrow_q <= diff[2];
			acc_q    <= sum[33:2];
			p_lo_q   <= {sum[1:0], p_lo_q[CNT_W-1:2]};
		end
	end

	assign done = busy_q && (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));
	assign neg  = borrow_q;
	assign p_hi = acc_q;
	assign p_lo = p_lo_q;

endmodule

// ===== src/gts_div.sv =====
module gts_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [gts_pkg::CNT_W+gts_pkg::HI_W-1:0] dividend,
	input  logic [gts_pkg::FREQ_W-1:0]            divisor,
	output logic                                  done,
	output logic [gts_pkg::CNT_W-1:0]             quotient
);
	import gts_pkg::*;

	localparam int DQ_W = CNT_W + HI_W;

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [FREQ_W-1:0]     div_q;
	logic [FREQ_W-1:0]     rem_q;
	logic [DQ_W-1:0]       dq_q;

	logic [FREQ_W:0]       t1;
	logic [FREQ_W:0]       t2;
	logic [FREQ_W+1:0]     sub1;
	logic [FREQ_W+1:0]     sub2;
	logic                  ge1;
	logic                  ge2;
	logic [FREQ_W-1:0]     r1;
	logic [FREQ_W-1:0]     r2;

	// Two restoring division steps per cycle; quotient bits enter at the bottom.
	always_comb begin
		t1   = {rem_q, dq_q[DQ_W-1]};
		sub1 = {1'b0, t1} - {2'b00, div_q};
		ge1  = !sub1[FREQ_W+1];
		r1   = ge1 ? sub1[FREQ_W-1:0] : t1[FREQ_W-1:0];
		t2   = {r1, dq_q[DQ_W-2]};
		sub2 = {1'b0, t2} - {2'b00, div_q};
		ge2  = !sub2[FREQ_W+1];
		r2   = ge2 ? sub2[FREQ_W-1:0] : t2[FREQ_W-1:0];
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= r2;
			dq_q  <= {dq_q[DQ_W-3:0], ge1, ge2};
		end
	end

	assign done     = busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign quotient = dq_q[CNT_W-1:0];

endmodule

// ===== src/gts_checker.sv =====
module gts_protocol_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [gts_pkg::CNT_W-1:0]      guest_ticks
);
	import gts_pkg::*;

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(guest_ticks))
		else $error("result changed while stalled");

	// An accepted request keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting a request");

	// A new result only appears at the end of a request in progress.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in progress");

	// Finishing a request always leaves a result in the output register.
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("request finished without a result");

endmodule

bind guest_timebase_scaler gts_protocol_checker u_gts_checker (.*);
